// ----- sv/sud_pkg.sv -----
// Shared types, constants and helper functions for the strict UTF-8 decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package sud_pkg;

	localparam int CP_W = 31;                      // width of a code point
	localparam int LEN_W = 3;                      // holds sequence lengths 0..6
	localparam int CNT_W = 2;                      // results per item, 0..2
	localparam logic [CP_W-1:0] INVALID_CODE_RESET = CP_W'(65533);

	localparam logic [CP_W-1:0] SURR_LO = CP_W'(32'h0000_d800);
	localparam logic [CP_W-1:0] SURR_HI = CP_W'(32'h0000_dfff);
	localparam logic [CP_W-1:0] NONCHAR_FFFE = CP_W'(32'h0000_fffe);
	localparam logic [CP_W-1:0] NONCHAR_FFFF = CP_W'(32'h0000_ffff);

	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;

	// One result item as it travels to the output.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            valid_res;
		logic            last;
	} sud_res_t;

	// Everything one input item produces.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		sud_res_t         r0;
		sud_res_t         r1;
	} sud_dec_t;

	// Least value that a sequence of the given length may encode.
	function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
		logic [CP_W-1:0] v;
		begin
			case (len)
				3'd2: v = CP_W'(32'h0000_0080);
				3'd3: v = CP_W'(32'h0000_0800);
				3'd4: v = CP_W'(32'h0001_0000);
				3'd5: v = CP_W'(32'h0020_0000);
				3'd6: v = CP_W'(32'h0400_0000);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// A finished sequence is accepted unless it is overlong, a surrogate,
	// or one of the two noncharacters at the end of the basic plane.
	function automatic logic acceptable(input logic [CP_W-1:0] c,
			input logic [LEN_W-1:0] len);
		logic ok;
		begin
			ok = 1'b1;
			if (len > 3'd6 || c < min_value(len)) ok = 1'b0;
			if (c >= SURR_LO && c <= SURR_HI) ok = 1'b0;
			if (c == NONCHAR_FFFE || c == NONCHAR_FFFF) ok = 1'b0;
			return ok;
		end
	endfunction

endpackage

`default_nettype wire

// ----- sv/sud_decode.sv -----
// Decoder state and the single-pass decode logic for one byte or flush.
// Depends on sud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sud_decode (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       cmd,
	input  wire logic [7:0]                 byte_in,
	input  wire logic [sud_pkg::CP_W-1:0]   invalid_code,
	output sud_pkg::sud_dec_t               dec
);
	import sud_pkg::*;

	logic [CP_W-1:0]  acc_q, acc_d, acc_ext;
	logic [LEN_W-1:0] rem_q, rem_d, len_q, len_d;
	logic             is_cont, lead, lead_has;
	logic [LEN_W-1:0] lead_len;
	logic [7:0]       lead_mask;
	sud_res_t         inv_res, lead_res;

	assign acc_ext = {acc_q[CP_W-7:0], byte_in[5:0]};
	assign is_cont = (byte_in[7:6] == 2'b10);

	always_comb begin
		inv_res = '{code_point: invalid_code, valid_res: 1'b0, last: 1'b0};
		// Classify the byte as a lead.
		lead_len = '0;
		lead_mask = 8'h00;
		lead_has = 1'b1;
		lead_res = inv_res;
		if (!byte_in[7]) begin
			lead_res = '{code_point: CP_W'(byte_in), valid_res: 1'b1, last: 1'b0};
		end else if (byte_in[7:5] == 3'b110) begin
			lead_has = 1'b0; lead_len = 3'd2; lead_mask = 8'h1f;
		end else if (byte_in[7:4] == 4'b1110) begin
			lead_has = 1'b0; lead_len = 3'd3; lead_mask = 8'h0f;
		end else if (byte_in[7:3] == 5'b11110) begin
			lead_has = 1'b0; lead_len = 3'd4; lead_mask = 8'h07;
		end else if (byte_in[7:2] == 6'b111110) begin
			lead_has = 1'b0; lead_len = 3'd5; lead_mask = 8'h03;
		end else if (byte_in[7:1] == 7'b1111110) begin
			lead_has = 1'b0; lead_len = 3'd6; lead_mask = 8'h01;
		end
		// Stray continuation and 0xFE/0xFF keep the invalid result above.

		dec = '0;
		acc_d = acc_q;
		rem_d = rem_q;
		len_d = len_q;
		lead = 1'b0;

		if (cmd == CMD_FLUSH[0]) begin
			if (rem_q != '0) begin
				dec.r0 = inv_res;
				dec.count = 2'd1;
				acc_d = '0; rem_d = '0; len_d = '0;
			end
		end else begin
			lead = 1'b1;
			if (rem_q != '0) begin
				if (is_cont) begin
					lead = 1'b0;
					acc_d = acc_ext;
					rem_d = rem_q - 3'd1;
					if (rem_q == 3'd1) begin
						if (acceptable(acc_ext, len_q)) begin
							dec.r0 = '{code_point: acc_ext, valid_res: 1'b1, last: 1'b0};
						end else begin
							dec.r0 = inv_res;
						end
						dec.count = 2'd1;
						acc_d = '0; rem_d = '0; len_d = '0;
					end
				end else begin
					// Broken sequence: report it, then treat the byte as a lead.
					dec.r0 = inv_res;
					dec.count = 2'd1;
					acc_d = '0; rem_d = '0; len_d = '0;
				end
			end
			if (lead) begin
				if (lead_has) begin
					if (dec.count == 2'd0) begin
						dec.r0 = lead_res;
						dec.count = 2'd1;
					end else begin
						dec.r1 = lead_res;
						dec.count = 2'd2;
					end
				end else begin
					acc_d = CP_W'(byte_in & lead_mask);
					len_d = lead_len;
					rem_d = lead_len - 3'd1;
				end
			end
		end

		if (dec.count == 2'd2) dec.r1.last = 1'b1;
		else if (dec.count == 2'd1) dec.r0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			len_q <= '0;
		end else if (step) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
			len_q <= len_d;
		end
	end

`ifndef SYNTH
	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) ? (rem_q == '0) : (rem_q < len_q && rem_q != '0))
		else $error("bytes remaining inconsistent with sequence length");
	a_two_only_on_break: assert property (@(posedge clk) disable iff (!arst_n)
		(step && dec.count == 2'd2) |-> (rem_q != '0 && !is_cont))
		else $error("two results without a broken sequence");
	a_flush_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cmd == CMD_FLUSH[0]) |=> (rem_q == '0 && len_q == '0))
		else $error("decoder not idle after a flush");
`endif

endmodule

`default_nettype wire

// ----- sv/sud_outbuf.sv -----
// Two-entry result buffer; the head entry drives the output stream.
// Depends on sud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sud_outbuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  sud_pkg::sud_dec_t        dec,
	input  wire logic                pop_ready,
	output logic                     head_valid,
	output sud_pkg::sud_res_t        head,
	output logic                     drain
);
	import sud_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	sud_res_t         slot0_q, slot1_q;
	logic             pop;

	assign head_valid = (cnt_q != '0);
	assign head = slot0_q;
	assign pop = head_valid && pop_ready;
	// The buffer is empty after this cycle, so a new item's results may enter.
	assign drain = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= dec.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= dec.r0;
			slot1_q <= dec.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");
	a_load_only_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> drain)
		else $error("results loaded over pending results");
	a_last_on_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (slot0_q.last == (cnt_q == 2'd1)))
		else $error("last flag does not match buffer position");
`endif

endmodule

`default_nettype wire

// ----- sv/strict_utf8_decoder_unit.sv -----
// Top level of the strict UTF-8 decoder: stream ports, input register,
// invalid-code register. Depends on sud_pkg, sud_decode and sud_outbuf.
//
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid/tready   | tdata: byte_in; tuser: cmd
// m_axis    | out       | m_axis_tvalid/tready   | tdata: code_point; tuser: valid_res;
//           |           |                        | tlast: last
// cfg       | in        | cfg_valid/cfg_ready    | cfg_data: invalid_code
//
// An accepted byte is registered in the input register, decoded from it and
// its results are registered into the result buffer that drives the output.
// One item per cycle is sustained while each item yields at most one result
// and the output is ready; an item yielding two results holds the input while
// the head entry drains the two-entry result buffer.
// Reset clears the decoder to idle, empties the buffer and restores
// invalid_code to 65533. A stalled output holds the input and decoder state.
`timescale 1ns / 1ps
`default_nettype none

module strict_utf8_decoder_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Input stream.
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [7:0]                s_axis_tdata,  // [7:0] byte_in
	input  wire logic                      s_axis_tuser,  // [0] cmd
	// Result stream.
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [31:0]                    m_axis_tdata,  // [30:0] code_point, [31] zero
	output logic                           m_axis_tuser,  // [0] valid_res
	output logic                           m_axis_tlast,  // last result of an item
	// Configuration write channel.
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [sud_pkg::CP_W-1:0]  cfg_data
);
	import sud_pkg::*;

	logic            valid_s1;
	logic            cmd_s1;
	logic [7:0]      byte_s1;
	logic [CP_W-1:0] invalid_code_q;
	logic            in_xfer, advance, drain;
	sud_dec_t        dec;
	sud_res_t        head;

	// Written whenever offered; the user must write only while idle, as nothing enforces it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_code_q <= INVALID_CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			invalid_code_q <= cfg_data;
		end
	end

	// The registered item moves on when the result buffer will be empty;
	// the input register takes a new transfer whenever it is empty or moving.
	assign advance = valid_s1 && drain;
	assign s_axis_tready = !valid_s1 || drain;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	sud_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.cmd          (cmd_s1),
		.byte_in      (byte_s1),
		.invalid_code (invalid_code_q),
		.dec          (dec)
	);

	sud_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.dec        (dec),
		.pop_ready  (m_axis_tready),
		.head_valid (m_axis_tvalid),
		.head       (head),
		.drain      (drain)
	);

	assign m_axis_tdata = {1'b0, head.code_point};
	assign m_axis_tuser = head.valid_res;
	assign m_axis_tlast = head.last;

`ifndef SYNTH
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !drain) |=> valid_s1)
		else $error("input register dropped an item");
	a_flush_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == CMD_FLUSH[0] && dec.count != 2'd0) |-> !dec.r0.valid_res)
		else $error("flush produced a well-formed result");
	a_ascii_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == CMD_DATA[0] && !byte_s1[7] && dec.count == 2'd1)
			|-> (dec.r0.valid_res && dec.r0.code_point == CP_W'(byte_s1)))
		else $error("single-byte character not passed through");
`endif

endmodule

`default_nettype wire

// ----- test/tb_strict_utf8_decoder_unit.sv -----
// Self-checking testbench for strict_utf8_decoder_unit: predicts every decoded
// character from its own decoder model and compares each output transfer in order.
// Depends on sud_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_strict_utf8_decoder_unit;
	import sud_pkg::*;

	localparam int SETTLE_CYCLES = 8;       // comfortably above the decoder latency
	localparam int TIMEOUT_NS = 5_000_000;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;      // [7:0] byte_in
	logic s_axis_tuser = 1'b0;             // [0] cmd
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;             // [30:0] code_point, [31] zero
	logic m_axis_tuser;                    // [0] valid_res
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CP_W-1:0] cfg_data = '0;

	// Decoder model state.
	logic [CP_W-1:0] model_invalid_code = INVALID_CODE_RESET;
	logic [CP_W-1:0] model_acc = '0;
	logic [2:0] model_left = '0;
	logic [2:0] model_len = '0;

	sud_res_t pending_chars[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int hold_cycles = 0;

	// Receiver stall pattern state.
	logic [15:0] rx_pattern = 16'hffff;
	int rx_phase = 0;
	int rx_pattern_age = 0;

	strict_utf8_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Least value a sequence of the given length may carry without being overlong.
	function automatic logic [CP_W-1:0] code_floor(input int len);
		case (len)
			2: return CP_W'(32'h80);
			3: return CP_W'(32'h800);
			4: return CP_W'(32'h10000);
			5: return CP_W'(32'h200000);
			6: return CP_W'(32'h4000000);
			default: return '0;
		endcase
	endfunction

	function automatic bit is_scalar_ok(input logic [CP_W-1:0] c, input int len);
		if (len > 6 || c < code_floor(len)) return 1'b0;
		if (c >= CP_W'(32'hd800) && c <= CP_W'(32'hdfff)) return 1'b0;
		if (c == CP_W'(32'hfffe) || c == CP_W'(32'hffff)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void push_char(input logic [CP_W-1:0] cp, input logic ok);
		sud_res_t r;
		r.code_point = cp;
		r.valid_res = ok;
		r.last = 1'b0;
		pending_chars.push_back(r);
	endfunction

	function automatic void close_sequence();
		model_acc = '0;
		model_left = '0;
		model_len = '0;
	endfunction

	// Runs one accepted input item through the model and queues its characters.
	function automatic void predict_decode(input logic [1:0] cmd, input logic [7:0] b);
		int first;
		bit as_lead;
		first = pending_chars.size();
		as_lead = 1'b1;
		if (cmd == CMD_FLUSH) begin
			if (model_left != 0) begin
				push_char(model_invalid_code, 1'b0);
				close_sequence();
			end
		end else begin
			if (model_left != 0) begin
				if (b[7:6] == 2'b10) begin
					as_lead = 1'b0;
					model_acc = {model_acc[CP_W-7:0], b[5:0]};
					model_left = model_left - 3'd1;
					if (model_left == 0) begin
						if (is_scalar_ok(model_acc, model_len))
							push_char(model_acc, 1'b1);
						else
							push_char(model_invalid_code, 1'b0);
						close_sequence();
					end
				end else begin
					// The interrupting byte is decoded again below as a new lead.
					push_char(model_invalid_code, 1'b0);
					close_sequence();
				end
			end
			if (as_lead) begin
				if (b < 8'h80) begin
					push_char(CP_W'(b), 1'b1);
				end else if (b < 8'hc0 || b >= 8'hfe) begin
					push_char(model_invalid_code, 1'b0);
				end else begin
					if (b < 8'he0) model_len = 3'd2;
					else if (b < 8'hf0) model_len = 3'd3;
					else if (b < 8'hf8) model_len = 3'd4;
					else if (b < 8'hfc) model_len = 3'd5;
					else model_len = 3'd6;
					model_acc = CP_W'(b & (8'h7f >> model_len));
					model_left = model_len - 3'd1;
				end
			end
		end
		if (pending_chars.size() > first)
			pending_chars[pending_chars.size()-1].last = 1'b1;
	endfunction

	// Result checker: every output transfer is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		sud_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result cp=%h valid=%b last=%b",
						$realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata !== {1'b0, want.code_point} ||
						m_axis_tuser !== want.valid_res || m_axis_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: mismatch exp cp=%h valid=%b last=%b, got cp=%h valid=%b last=%b",
							$realtime, {1'b0, want.code_point}, want.valid_res, want.last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end
			end
		end
	end

	// Receiver: a long hold when one is requested, otherwise a rotating stall pattern
	// that is replaced when its random age runs out (sometimes by no stalls at all).
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles--;
		end else begin
			if (rx_pattern_age == 0) begin
				if ($urandom_range(0, 3) == 0)
					rx_pattern = 16'hffff;
				else
					rx_pattern = 16'($urandom()) | (16'h1 << $urandom_range(0, 15));
				rx_pattern_age = $urandom_range(50, 300);
			end
			rx_pattern_age--;
			m_axis_tready <= rx_pattern[rx_phase % 16];
			rx_phase++;
		end
	end

	// Sends one item, opening a random gap first whenever the current burst is spent.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= cmd[0];
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		// A flush with no open sequence changes nothing, so it is not counted.
		if (!(cmd == CMD_FLUSH && model_left == 0))
			items_sent++;
		predict_decode(cmd, b);
	endtask

	task automatic send_bytes(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_item(CMD_DATA, seq[i]);
	endtask

	// Stops sending and waits until every predicted character has been received.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_invalid_code(input logic [CP_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_invalid_code = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CP_W-1:0] pick_value(input int len);
		logic [31:0] lo;
		logic [31:0] hi;
		int bits;
		int sel;
		bits = (len == 1) ? 7 : 5 * len + 1;
		lo = 32'(code_floor(len));
		hi = (32'h1 << bits) - 1;
		sel = $urandom_range(0, 15);
		if (sel == 0) return CP_W'(lo);
		if (sel == 1) return CP_W'(hi);
		if (sel == 2 && len > 1) return CP_W'($urandom_range(0, lo - 1));
		if (sel == 3 && len >= 3) begin
			case ($urandom_range(0, 6))
				0: return CP_W'(32'hd7ff);
				1: return CP_W'(32'hd800);
				2: return CP_W'(32'hdfff);
				3: return CP_W'(32'he000);
				4: return CP_W'(32'hfffd);
				5: return CP_W'(32'hfffe);
				default: return CP_W'(32'hffff);
			endcase
		end
		return CP_W'($urandom_range(lo, hi));
	endfunction

	// Builds the bytes of a value in a sequence of the given length (overlong allowed).
	function automatic void build_sequence(input logic [CP_W-1:0] v, input int len,
			ref logic [7:0] seq[$]);
		logic [31:0] wide;
		wide = {1'b0, v};
		seq.delete();
		if (len == 1) begin
			seq.push_back({1'b0, wide[6:0]});
		end else begin
			seq.push_back(~(8'hff >> len) | (8'(wide >> (6 * (len - 1))) & (8'h7f >> len)));
			for (int k = len - 2; k >= 0; k--)
				seq.push_back({2'b10, 6'(wide >> (6 * k))});
		end
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return 1;
		if (r < 40) return 2;
		if (r < 65) return 3;
		if (r < 80) return 4;
		if (r < 90) return 5;
		return 6;
	endfunction

	function automatic logic [7:0] non_continuation_byte();
		logic [7:0] b;
		b = 8'($urandom());
		if (b[7:6] == 2'b10) begin
			if ($urandom_range(0, 1)) b[7] = 1'b0;
			else b[6] = 1'b1;
		end
		return b;
	endfunction

	// Extremes of the byte range, each rejection rule, an interruption that yields
	// two results, and both kinds of flush.
	task automatic test_directed_cases();
		send_bytes('{8'h00, 8'h7f, 8'h80, 8'hff, 8'hfe});
		send_bytes('{8'hc0, 8'h80});                             // overlong two-byte form
		send_bytes('{8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf}); // largest six-byte value
		send_bytes('{8'hed, 8'ha0, 8'h80});                      // surrogate
		send_bytes('{8'hef, 8'hbf, 8'hbe});                      // noncharacter FFFE
		send_bytes('{8'hc3, 8'h41});                             // interrupted, then ASCII
		send_bytes('{8'he2, 8'hff});                             // interrupted by a bad lead
		send_bytes('{8'hf0, 8'h90});
		send_item(CMD_FLUSH, 8'hff);                              // flush of an open sequence
		send_item(CMD_FLUSH, 8'h00);                              // flush while idle
		drain_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// items, so the buffer fills and the input stalls.
	task automatic test_output_hold();
		logic [7:0] seq[$];
		int len;
		hold_cycles = 400;
		repeat (30) begin
			len = pick_length();
			build_sequence(pick_value(len), len, seq);
			send_bytes(seq);
		end
		drain_results();
	endtask

	task automatic test_random_stream(input int item_target);
		logic [7:0] seq[$];
		int start;
		int kind;
		int len;
		int cut;
		start = items_sent;
		while (items_sent - start < item_target) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				len = pick_length();
				build_sequence(pick_value(len), len, seq);
				send_bytes(seq);
			end else if (kind < 80) begin
				// Truncated sequence, ended by whatever comes next or by a flush.
				len = $urandom_range(2, 6);
				build_sequence(pick_value(len), len, seq);
				cut = $urandom_range(1, len - 1);
				for (int i = 0; i < cut; i++)
					send_item(CMD_DATA, seq[i]);
				if ($urandom_range(0, 1))
					send_item(CMD_FLUSH, 8'($urandom()));
			end else if (kind < 88) begin
				repeat ($urandom_range(1, 4))
					send_item(CMD_DATA, 8'($urandom()));
			end else if (kind < 92) begin
				send_item(CMD_FLUSH, 8'($urandom()));
			end else begin
				// A continuation position replaced by a byte that cannot continue.
				len = $urandom_range(2, 6);
				build_sequence(pick_value(len), len, seq);
				seq[$urandom_range(1, len - 1)] = non_continuation_byte();
				send_bytes(seq);
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_output_hold();
		write_invalid_code('0);
		test_random_stream(310);
		write_invalid_code({CP_W{1'b1}});
		test_random_stream(310);
		write_invalid_code(CP_W'($urandom()));
		test_random_stream(310);
		write_invalid_code(INVALID_CODE_RESET);
		test_random_stream(310);

		drain_results();
		if (mismatch_count == 0 && pending_chars.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
